### rtl/snmpx_pkg.sv
// ----------------------------------------------------------------------------
// SNMPv1 field extractor package
// Shared constants, result codes and the result bundle type.
// ----------------------------------------------------------------------------
package snmpx_pkg;

   localparam int unsigned MaxMessageBytes   = 65535;
   localparam logic [7:0]  MinLengthReset    = 8'd18;
   localparam int unsigned QueueDepthDefault = 4;
   localparam int unsigned BundleSlots       = 3;

   typedef logic [3:0] kind_type;
   typedef logic [1:0] status_type;

   localparam kind_type KIND_NONE      = 4'd0;
   localparam kind_type KIND_VERSION   = 4'd0;
   localparam kind_type KIND_COMMUNITY = 4'd1;
   localparam kind_type KIND_PDU_TYPE  = 4'd2;
   localparam kind_type KIND_REQ_ID    = 4'd3;
   localparam kind_type KIND_TRAP_BASE = 4'd6;
   localparam kind_type KIND_NAME      = 4'd11;
   localparam kind_type KIND_INT       = 4'd12;
   localparam kind_type KIND_STRING    = 4'd13;
   localparam kind_type KIND_OID       = 4'd14;
   localparam kind_type KIND_NULL      = 4'd15;

   localparam status_type STATUS_BUSY   = 2'd0;
   localparam status_type STATUS_ACCEPT = 2'd1;
   localparam status_type STATUS_REJECT = 2'd2;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] value;
      logic        last;
      status_type  status;
   } result_type;

   // Up to three results produced by one input byte.
   typedef struct packed {
      logic [1:0]       count;
      result_type [2:0] items;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } push_type;

   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } head_type;

   function automatic bundle_type bundle_push(bundle_type bu, result_type r);
      bundle_type o;
      o = bu;
      if (o.count < 2'(BundleSlots)) begin
         o.items[o.count] = r;
         o.count = o.count + 2'd1;
      end
      return o;
   endfunction

   function automatic result_type make_result(kind_type k, logic [31:0] v, logic l,
                                              status_type s);
      result_type r;
      r.kind   = k;
      r.value  = v;
      r.last   = l;
      r.status = s;
      return r;
   endfunction

endpackage

### rtl/snmpx_if.sv
// ----------------------------------------------------------------------------
// SNMPv1 field extractor channels
// Valid/ready channels for byte requests, results and the length register.
// ----------------------------------------------------------------------------
interface snmpx_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        start_of_message;
   logic [15:0] message_length;
   modport source(output valid, data_byte, start_of_message, message_length, input ready);
   modport sink(input valid, data_byte, start_of_message, message_length, output ready);
endinterface

interface snmpx_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  field_kind;
   logic [31:0] field_value;
   logic        field_last;
   logic [1:0]  message_status;
   modport source(output valid, field_kind, field_value, field_last, message_status,
                  input ready);
   modport sink(input valid, field_kind, field_value, field_last, message_status,
                output ready);
endinterface

interface snmpx_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

### rtl/snmpx_front.sv
// ----------------------------------------------------------------------------
// SNMPv1 BER parser front end
// Consumes one byte per request and produces the results that byte causes.
// ----------------------------------------------------------------------------
module snmpx_front (
   input  logic                 clock,
   input  logic                 reset,
   snmpx_req_if.sink            req_chan,
   input  logic [7:0]           min_length,
   input  logic                 queue_full,
   output snmpx_pkg::push_type  push
);
   import snmpx_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_MSG, PH_HDR, PH_PDU, PH_GET, PH_TRAP,
      PH_VBLIST, PH_VB, PH_NAME, PH_VALUE, PH_TRAIL, PH_FAIL
   } phase_type;

   typedef enum logic [1:0] {ST_TAG, ST_LEN1, ST_LENX, ST_BODY} stage_type;
   typedef enum logic [2:0] {MD_SKIP, MD_INT, MD_BYTES, MD_OID, MD_NULL} mode_type;

   phase_type   phase_ff, phase_in;
   stage_type   stage_ff, stage_in;
   logic [15:0] msg_left_ff, msg_left_in;
   logic [15:0] pdu_left_ff, pdu_left_in;
   logic [15:0] vb_left_ff, vb_left_in;
   logic [6:0]  class_tag_ff, class_tag_in;
   logic [31:0] content_left_ff, content_left_in;
   logic [2:0]  len_oct_ff, len_oct_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  groups_ff, groups_in;
   logic [2:0]  hdr_idx_ff, hdr_idx_in;

   logic        accept;
   logic        ok;
   logic        ended;
   logic        hdr_go;
   logic [31:0] hdr_len;
   logic        fe_go;
   logic        fe_empty;
   logic        last_byte;
   logic [15:0] limit;
   logic [1:0]  oid_x;
   logic [31:0] oid_y;
   mode_type    mode;
   kind_type    kind;
   bundle_type  bu;
   logic [7:0]  b;

   function automatic mode_type mode_of(phase_type ph, logic [2:0] hi, logic [6:0] ct);
      mode_type m;
      m = MD_SKIP;
      case (ph)
         PH_HDR:  m = (hi == 3'd0) ? MD_INT : MD_BYTES;
         PH_GET:  m = MD_INT;
         PH_TRAP: m = (hi == 3'd0) ? MD_OID : ((hi == 3'd1) ? MD_BYTES : MD_INT);
         PH_NAME: m = MD_OID;
         PH_VALUE: begin
            if (ct[6:5] == 2'd0) begin
               case (ct[4:0])
                  5'd2:    m = MD_INT;
                  5'd4:    m = MD_BYTES;
                  5'd5:    m = MD_NULL;
                  5'd6:    m = MD_OID;
                  default: m = MD_SKIP;
               endcase
            end else if (ct[6:5] == 2'd1) begin
               if (ct[4:0] inside {[5'd1:5'd3]}) m = MD_INT;
               else if (ct[4:0] inside {5'd0, 5'd4}) m = MD_BYTES;
            end
         end
         default: m = MD_SKIP;
      endcase
      return m;
   endfunction

   function automatic kind_type kind_of(phase_type ph, logic [2:0] hi, mode_type m);
      kind_type k;
      case (ph)
         PH_HDR:  k = (hi != 3'd0) ? KIND_COMMUNITY : KIND_VERSION;
         PH_GET:  k = KIND_REQ_ID + kind_type'(hi[1:0]);
         PH_TRAP: k = KIND_TRAP_BASE + kind_type'(hi);
         PH_NAME: k = KIND_NAME;
         default: begin
            case (m)
               MD_INT:   k = KIND_INT;
               MD_BYTES: k = KIND_STRING;
               MD_OID:   k = KIND_OID;
               default:  k = KIND_NULL;
            endcase
         end
      endcase
      return k;
   endfunction

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.data_byte;

   always_comb begin
      phase_in        = phase_ff;
      stage_in        = stage_ff;
      msg_left_in     = msg_left_ff;
      pdu_left_in     = pdu_left_ff;
      vb_left_in      = vb_left_ff;
      class_tag_in    = class_tag_ff;
      content_left_in = content_left_ff;
      len_oct_in      = len_oct_ff;
      acc_in          = acc_ff;
      groups_in       = groups_ff;
      hdr_idx_in      = hdr_idx_ff;
      bu              = '0;
      ok              = 1'b1;
      ended           = 1'b0;
      hdr_go          = 1'b0;
      hdr_len         = '0;
      fe_go           = 1'b0;
      fe_empty        = 1'b0;
      last_byte       = 1'b0;
      limit           = '0;
      oid_x           = '0;
      oid_y           = '0;
      mode            = MD_SKIP;
      kind            = KIND_NONE;

      if (req_chan.start_of_message) begin
         pdu_left_in     = '0;
         vb_left_in      = '0;
         class_tag_in    = '0;
         content_left_in = '0;
         len_oct_in      = '0;
         acc_in          = '0;
         groups_in       = '0;
         hdr_idx_in      = '0;
         stage_in        = ST_TAG;
         msg_left_in     = req_chan.message_length;
         if ((req_chan.message_length < {8'd0, min_length}) ||
             (32'(req_chan.message_length) > 32'(MaxMessageBytes))) begin
            phase_in = PH_FAIL;
         end else begin
            phase_in = PH_MSG;
         end
      end

      if (phase_in != PH_IDLE) begin
         ended = (msg_left_in <= 16'd1);
         if (msg_left_in != 16'd0) msg_left_in = msg_left_in - 16'd1;

         if (phase_in != PH_FAIL && phase_in != PH_TRAIL) begin
            // Bytes inside the PDU and the varbind list count against their lengths.
            if (phase_in >= PH_GET && phase_in <= PH_VALUE) begin
               if (pdu_left_in == 16'd0) ok = 1'b0;
               else pdu_left_in = pdu_left_in - 16'd1;
            end
            if (ok && phase_in >= PH_VB && phase_in <= PH_VALUE) begin
               if (vb_left_in == 16'd0) ok = 1'b0;
               else vb_left_in = vb_left_in - 16'd1;
            end

            if (ok) begin
               case (stage_in)
                  ST_TAG: begin
                     class_tag_in = {b[7:6], b[4:0]};
                     if (phase_in == PH_MSG || phase_in == PH_VBLIST || phase_in == PH_VB) begin
                        if (b[7:6] != 2'd0 || b[4:0] != 5'd16) ok = 1'b0;
                     end else if (phase_in == PH_PDU) begin
                        if (b[7:6] != 2'd2 || b[4:0] > 5'd4) ok = 1'b0;
                        else bu = bundle_push(bu, make_result(KIND_PDU_TYPE,
                                              {27'd0, b[4:0]}, 1'b1, STATUS_BUSY));
                     end
                     if (ok) stage_in = ST_LEN1;
                  end
                  ST_LEN1: begin
                     if (b[7]) begin
                        if (b[6:0] > 7'd4) ok = 1'b0;
                        else if (b[6:0] == 7'd0) hdr_go = 1'b1;
                        else begin
                           len_oct_in      = b[2:0];
                           content_left_in = '0;
                           stage_in        = ST_LENX;
                        end
                     end else begin
                        hdr_go  = 1'b1;
                        hdr_len = {24'd0, b};
                     end
                  end
                  ST_LENX: begin
                     content_left_in = {content_left_in[23:0], b};
                     if (len_oct_in != 3'd0) len_oct_in = len_oct_in - 3'd1;
                     if (len_oct_in == 3'd0) begin
                        hdr_go  = 1'b1;
                        hdr_len = content_left_in;
                     end
                  end
                  default: begin
                     mode      = mode_of(phase_in, hdr_idx_in, class_tag_in);
                     kind      = kind_of(phase_in, hdr_idx_in, mode);
                     last_byte = (content_left_in == 32'd1);
                     if (content_left_in != 32'd0) content_left_in = content_left_in - 32'd1;
                     if (mode == MD_INT) begin
                        acc_in = {acc_in[23:0], b};
                        if (last_byte) bu = bundle_push(bu, make_result(kind, acc_in, 1'b1,
                                                        STATUS_BUSY));
                     end else if (mode == MD_BYTES) begin
                        bu = bundle_push(bu, make_result(kind, {24'd0, b}, last_byte,
                                                         STATUS_BUSY));
                     end else if (mode == MD_OID) begin
                        acc_in    = {acc_in[24:0], b[6:0]};
                        groups_in = groups_in + 3'd1;
                        if (!b[7] || groups_in >= 3'd5 || last_byte) begin
                           if (len_oct_in != 3'd0) begin
                              // First subid carries the first two arcs.
                              if (acc_in < 32'd40) begin
                                 oid_x = 2'd0;
                                 oid_y = acc_in;
                              end else if (acc_in < 32'd80) begin
                                 oid_x = 2'd1;
                                 oid_y = acc_in - 32'd40;
                              end else begin
                                 oid_x = 2'd2;
                                 oid_y = acc_in - 32'd80;
                              end
                              bu = bundle_push(bu, make_result(kind, {30'd0, oid_x}, 1'b0,
                                                               STATUS_BUSY));
                              bu = bundle_push(bu, make_result(kind, oid_y, last_byte,
                                                               STATUS_BUSY));
                              len_oct_in = '0;
                           end else begin
                              bu = bundle_push(bu, make_result(kind, acc_in, last_byte,
                                                               STATUS_BUSY));
                           end
                           acc_in    = '0;
                           groups_in = '0;
                        end
                     end
                     if (last_byte) fe_go = 1'b1;
                  end
               endcase
            end

            if (ok && hdr_go) begin
               if (phase_in <= PH_PDU) limit = msg_left_in;
               else if (phase_in <= PH_VBLIST) limit = pdu_left_in;
               else limit = vb_left_in;
               if (hdr_len > {16'd0, limit}) begin
                  ok = 1'b0;
               end else begin
                  stage_in = ST_TAG;
                  case (phase_in)
                     PH_MSG: begin
                        phase_in   = PH_HDR;
                        hdr_idx_in = '0;
                     end
                     PH_PDU: begin
                        pdu_left_in = hdr_len[15:0];
                        phase_in    = (class_tag_in[4:0] == 5'd4) ? PH_TRAP : PH_GET;
                        hdr_idx_in  = '0;
                     end
                     PH_VBLIST: begin
                        vb_left_in = hdr_len[15:0];
                        phase_in   = (hdr_len == 32'd0) ? PH_TRAIL : PH_VB;
                     end
                     PH_VB: begin
                        phase_in = (vb_left_in == 16'd0) ? PH_TRAIL : PH_NAME;
                     end
                     default: begin
                        content_left_in = hdr_len;
                        acc_in          = '0;
                        groups_in       = '0;
                        len_oct_in      = 3'd1;
                        if (hdr_len == 32'd0) begin
                           fe_go    = 1'b1;
                           fe_empty = 1'b1;
                        end else begin
                           stage_in = ST_BODY;
                        end
                     end
                  endcase
               end
            end

            if (ok && fe_go) begin
               mode = mode_of(phase_in, hdr_idx_in, class_tag_in);
               kind = kind_of(phase_in, hdr_idx_in, mode);
               if (mode == MD_NULL) begin
                  bu = bundle_push(bu, make_result(KIND_NULL, '0, 1'b1, STATUS_BUSY));
               end else if (mode == MD_INT && fe_empty) begin
                  bu = bundle_push(bu, make_result(kind, '0, 1'b1, STATUS_BUSY));
               end
               stage_in = ST_TAG;
               case (phase_in)
                  PH_HDR: begin
                     if (hdr_idx_in == 3'd0) hdr_idx_in = 3'd1;
                     else begin
                        hdr_idx_in = '0;
                        phase_in   = PH_PDU;
                     end
                  end
                  PH_GET: begin
                     if (hdr_idx_in < 3'd2) hdr_idx_in = hdr_idx_in + 3'd1;
                     else begin
                        hdr_idx_in = '0;
                        phase_in   = PH_VBLIST;
                     end
                  end
                  PH_TRAP: begin
                     if (hdr_idx_in < 3'd4) hdr_idx_in = hdr_idx_in + 3'd1;
                     else begin
                        hdr_idx_in = '0;
                        phase_in   = PH_VBLIST;
                     end
                  end
                  PH_NAME:  phase_in = PH_VALUE;
                  PH_VALUE: phase_in = PH_VB;
                  default:  phase_in = phase_in;
               endcase
               if (phase_in >= PH_VB && phase_in <= PH_VALUE && vb_left_in == 16'd0) begin
                  phase_in = PH_TRAIL;
               end
            end

            if (!ok) begin
               phase_in = PH_FAIL;
               stage_in = ST_TAG;
            end
         end

         if (ended) begin
            bu = bundle_push(bu, make_result(KIND_NONE, '0, 1'b0,
                             (phase_in == PH_TRAIL) ? STATUS_ACCEPT : STATUS_REJECT));
            phase_in    = PH_IDLE;
            stage_in    = ST_TAG;
            msg_left_in = '0;
         end
      end
   end

   assign push.valid  = accept && (bu.count != 2'd0);
   assign push.bundle = bu;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         stage_ff        <= ST_TAG;
         msg_left_ff     <= '0;
         pdu_left_ff     <= '0;
         vb_left_ff      <= '0;
         class_tag_ff    <= '0;
         content_left_ff <= '0;
         len_oct_ff      <= '0;
         acc_ff          <= '0;
         groups_ff       <= '0;
         hdr_idx_ff      <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         stage_ff        <= stage_in;
         msg_left_ff     <= msg_left_in;
         pdu_left_ff     <= pdu_left_in;
         vb_left_ff      <= vb_left_in;
         class_tag_ff    <= class_tag_in;
         content_left_ff <= content_left_in;
         len_oct_ff      <= len_oct_in;
         acc_ff          <= acc_in;
         groups_ff       <= groups_in;
         hdr_idx_ff      <= hdr_idx_in;
      end
   end

endmodule

### rtl/snmpx_queue.sv
// ----------------------------------------------------------------------------
// SNMPv1 result bundle queue
// Small FIFO of result bundles between the parser and the output stage.
// ----------------------------------------------------------------------------
module snmpx_queue #(
   parameter int unsigned DEPTH = snmpx_pkg::QueueDepthDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  snmpx_pkg::push_type  push,
   input  logic                 pop,
   output snmpx_pkg::head_type  head,
   output logic                 full
);
   import snmpx_pkg::*;

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);

   bundle_type            entry_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_wr;
   logic                  do_rd;

   assign full        = (count_ff == CntWidth'(DEPTH));
   assign head.valid  = (count_ff != '0);
   assign head.bundle = entry_ff[rd_ptr_ff];
   assign do_wr       = push.valid && !full;
   assign do_rd       = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) count_in = count_ff + 1'b1;
      else if (!do_wr && do_rd) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) entry_ff[wr_ptr_ff] <= push.bundle;
   end

endmodule

### rtl/snmpx_back.sv
// ----------------------------------------------------------------------------
// SNMPv1 result output stage
// Unpacks queued bundles into single results behind an output register.
// ----------------------------------------------------------------------------
module snmpx_back (
   input  logic                 clock,
   input  logic                 reset,
   input  snmpx_pkg::head_type  head,
   output logic                 pop,
   snmpx_rsp_if.source          rsp_chan
);
   import snmpx_pkg::*;

   logic        valid_ff;
   result_type  out_ff;
   logic [1:0]  idx_ff;
   logic        load;
   logic        last_of;

   assign load    = head.valid && (!valid_ff || rsp_chan.ready);
   assign last_of = (idx_ff == head.bundle.count - 2'd1);
   assign pop     = load && last_of;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= last_of ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) out_ff <= head.bundle.items[idx_ff];
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.field_kind     = out_ff.kind;
   assign rsp_chan.field_value    = out_ff.value;
   assign rsp_chan.field_last     = out_ff.last;
   assign rsp_chan.message_status = out_ff.status;

endmodule

### rtl/snmp_v1_message_field_extractor_core.sv
// ----------------------------------------------------------------------------
// SNMPv1 message field extractor
// Streams BER-encoded SNMPv1 messages and emits the decoded fields and verdict.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   req_chan  in         one message byte, start flag and message length
//   rsp_chan  out        field kind, value, last flag and message status
//   csr_chan  in         minimum message length register write
//
// A byte request is taken in every cycle while the bundle queue has room; the
// parser front end decodes that byte in the same cycle and queues the up to
// three results it causes. The output stage hands out one result per cycle while
// the result side is ready, so a byte that causes two or three results holds the
// output through each in turn; the queue depth sets how much of that the input may run ahead.
// Reset is synchronous and returns the parser to idle with an empty queue;
// the minimum length register returns to 18. A stalled result side holds the
// output register and lets the queue fill before the request side stalls.
//
module snmp_v1_message_field_extractor_core #(
   parameter int unsigned QUEUE_DEPTH = snmpx_pkg::QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   snmpx_req_if.sink  req_chan,
   snmpx_rsp_if.source rsp_chan,
   snmpx_csr_if.sink  csr_chan
);
   import snmpx_pkg::*;

   logic [7:0] min_length_ff;
   push_type   push;
   head_type   head;
   logic       pop;
   logic       queue_full;

   // The register is always writable; write it only while idle (not enforced).
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MinLengthReset;
      end else if (csr_chan.valid) begin
         min_length_ff <= csr_chan.data;
      end
   end

   // Front end: byte-wise BER parse into result bundles.
   snmpx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .min_length (min_length_ff),
      .queue_full (queue_full),
      .push       (push)
   );

   // Decoupling queue between the parser and the output stage.
   snmpx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   // Back end: one result per ready cycle through the output register.
   snmpx_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

### test/tb_snmp_v1_message_field_extractor_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SNMPv1 field extractor testbench
// Feeds BER-encoded SNMPv1 messages, some well formed and some broken, one
// byte per request. A decoder model in the bench predicts every field and
// verdict, or a stimulus row types in its own; results are checked in order.
// ----------------------------------------------------------------------------
module tb_snmp_v1_message_field_extractor_core;
   import snmpx_pkg::*;

   typedef enum logic [3:0] {
      PS_IDLE, PS_SEQ, PS_COMMON, PS_PDU, PS_GETHDR, PS_TRAPHDR,
      PS_LIST, PS_BIND, PS_NAME, PS_VALUE, PS_TAIL, PS_DEAD
   } decode_phase_type;
   typedef enum logic [1:0] {T_TAG, T_LEN, T_LENX, T_BODY} tlv_part_type;
   typedef enum logic [2:0] {M_SKIP, M_INT, M_BYTES, M_OID, M_NULL} field_mode_type;
   typedef logic [7:0] octets_type[$];

   typedef struct {
      logic [7:0]  d;
      logic        sof;
      logic [15:0] len;
      int          typed_n;
      result_type  r;
   } stim_row_type;

   localparam result_type VERDICT_REJECT =
      '{kind: KIND_NONE, value: 32'd0, last: 1'b0, status: STATUS_REJECT};
   localparam result_type NO_RESULT = '0;

   logic clock;
   logic reset;

   snmpx_req_if req ();
   snmpx_rsp_if rsp ();
   snmpx_csr_if csr ();

   snmp_v1_message_field_extractor_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   // Decoder model state.
   logic [7:0]       min_len;
   decode_phase_type ph;
   tlv_part_type     part;
   logic [31:0]   msg_left, pdu_left, vb_left, cls_tag, cnt_left, len_oct, acc, groups, hdr_idx;

   result_type step_out[$];
   result_type fields_due[$];

   int  typed_count;
   result_type typed_res;
   bit  calm;
   int  sent, errors, n_fields, n_accept, n_reject, n_msgs;

   // ------------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------------
   function automatic void put_field(kind_type k, logic [31:0] v, logic l, status_type s);
      result_type r;
      if (step_out.size() >= 3) return;
      r.kind = k;
      r.value = v;
      r.last = l;
      r.status = s;
      step_out.push_back(r);
   endfunction

   function automatic void go_dead();
      ph = PS_DEAD;
      part = T_TAG;
   endfunction

   function automatic field_mode_type field_mode();
      logic [1:0] c;
      logic [4:0] t;
      c = cls_tag[6:5];
      t = cls_tag[4:0];
      case (ph)
         PS_COMMON: return (hdr_idx == 0) ? M_INT : M_BYTES;
         PS_GETHDR: return M_INT;
         PS_TRAPHDR: begin
            if (hdr_idx == 0) return M_OID;
            return (hdr_idx == 1) ? M_BYTES : M_INT;
         end
         PS_NAME: return M_OID;
         PS_VALUE: begin
            if (c == 2'd0) begin
               if (t == 5'd2) return M_INT;
               if (t == 5'd4) return M_BYTES;
               if (t == 5'd5) return M_NULL;
               if (t == 5'd6) return M_OID;
            end else if (c == 2'd1) begin
               if (t >= 5'd1 && t <= 5'd3) return M_INT;
               if (t == 5'd0 || t == 5'd4) return M_BYTES;
            end
            return M_SKIP;
         end
         default: return M_SKIP;
      endcase
   endfunction

   function automatic kind_type kind_for(field_mode_type m);
      case (ph)
         PS_COMMON:  return (hdr_idx != 0) ? KIND_COMMUNITY : KIND_VERSION;
         PS_GETHDR:  return KIND_REQ_ID + kind_type'(hdr_idx[1:0]);
         PS_TRAPHDR: return KIND_TRAP_BASE + kind_type'(hdr_idx[2:0]);
         PS_NAME:    return KIND_NAME;
         default: begin
            if (m == M_INT) return KIND_INT;
            if (m == M_BYTES) return KIND_STRING;
            if (m == M_OID) return KIND_OID;
            return KIND_NULL;
         end
      endcase
   endfunction

   function automatic void end_of_list();
      if (ph >= PS_BIND && ph <= PS_VALUE && vb_left == 0) ph = PS_TAIL;
   endfunction

   function automatic void close_element(bit empty);
      field_mode_type m;
      m = field_mode();
      if (m == M_NULL) put_field(KIND_NULL, 32'd0, 1'b1, STATUS_BUSY);
      else if (m == M_INT && empty) put_field(kind_for(m), 32'd0, 1'b1, STATUS_BUSY);
      part = T_TAG;
      case (ph)
         PS_COMMON: begin
            if (hdr_idx == 0) hdr_idx = 1;
            else begin
               hdr_idx = 0;
               ph = PS_PDU;
            end
         end
         PS_GETHDR: begin
            if (hdr_idx < 2) hdr_idx++;
            else begin
               hdr_idx = 0;
               ph = PS_LIST;
            end
         end
         PS_TRAPHDR: begin
            if (hdr_idx < 4) hdr_idx++;
            else begin
               hdr_idx = 0;
               ph = PS_LIST;
            end
         end
         PS_NAME:  ph = PS_VALUE;
         PS_VALUE: ph = PS_BIND;
         default: ;
      endcase
      end_of_list();
   endfunction

   function automatic void open_contents(logic [31:0] len);
      logic [31:0] limit;
      if (ph <= PS_PDU) limit = msg_left;
      else if (ph <= PS_LIST) limit = pdu_left;
      else limit = vb_left;
      if (len > limit) begin
         go_dead();
         return;
      end
      part = T_TAG;
      case (ph)
         PS_SEQ: begin
            ph = PS_COMMON;
            hdr_idx = 0;
         end
         PS_PDU: begin
            pdu_left = len;
            ph = (cls_tag[4:0] == 5'd4) ? PS_TRAPHDR : PS_GETHDR;
            hdr_idx = 0;
         end
         PS_LIST: begin
            vb_left = len;
            ph = (len == 0) ? PS_TAIL : PS_BIND;
         end
         PS_BIND: begin
            ph = PS_NAME;
            end_of_list();
         end
         default: begin
            cnt_left = len;
            acc = 0;
            groups = 0;
            len_oct = 1;   // doubles as "first subidentifier still to come"
            if (len == 0) close_element(1'b1);
            else part = T_BODY;
         end
      endcase
   endfunction

   function automatic void content_byte(logic [7:0] b);
      field_mode_type m;
      kind_type    k;
      bit          last;
      logic [31:0] x;
      m = field_mode();
      k = kind_for(m);
      last = (cnt_left == 1);
      if (cnt_left != 0) cnt_left--;
      case (m)
         M_INT: begin
            acc = (acc << 8) | b;
            if (last) put_field(k, acc, 1'b1, STATUS_BUSY);
         end
         M_BYTES: put_field(k, {24'd0, b}, last, STATUS_BUSY);
         M_OID: begin
            acc = (acc << 7) | b[6:0];
            groups++;
            if (!b[7] || groups >= 5 || last) begin
               if (len_oct != 0) begin
                  // The first subidentifier carries two arcs.
                  x = (acc < 40) ? 0 : ((acc < 80) ? 1 : 2);
                  put_field(k, x, 1'b0, STATUS_BUSY);
                  put_field(k, acc - 40 * x, last, STATUS_BUSY);
                  len_oct = 0;
               end else begin
                  put_field(k, acc, last, STATUS_BUSY);
               end
               acc = 0;
               groups = 0;
            end
         end
         default: ;
      endcase
      if (last) close_element(1'b0);
   endfunction

   function automatic void tlv_byte(logic [7:0] b);
      logic [1:0] c;
      logic [4:0] t;
      if (ph >= PS_GETHDR && ph <= PS_VALUE) begin
         if (pdu_left == 0) begin
            go_dead();
            return;
         end
         pdu_left--;
      end
      if (ph >= PS_BIND && ph <= PS_VALUE) begin
         if (vb_left == 0) begin
            go_dead();
            return;
         end
         vb_left--;
      end
      case (part)
         T_TAG: begin
            c = b[7:6];
            t = b[4:0];
            cls_tag = {25'd0, c, t};
            if (ph == PS_SEQ || ph == PS_LIST || ph == PS_BIND) begin
               if (c != 2'd0 || t != 5'd16) begin
                  go_dead();
                  return;
               end
            end else if (ph == PS_PDU) begin
               if (c != 2'd2 || t > 5'd4) begin
                  go_dead();
                  return;
               end
               put_field(KIND_PDU_TYPE, {27'd0, t}, 1'b1, STATUS_BUSY);
            end
            part = T_LEN;
         end
         T_LEN: begin
            if (b[7]) begin
               if (b[6:0] > 7'd4) begin
                  go_dead();
                  return;
               end
               if (b[6:0] == 7'd0) begin
                  open_contents(32'd0);
                  return;
               end
               len_oct = {25'd0, b[6:0]};
               cnt_left = 0;
               part = T_LENX;
            end else begin
               open_contents({24'd0, b});
            end
         end
         T_LENX: begin
            cnt_left = (cnt_left << 8) | b;
            if (len_oct != 0) len_oct--;
            if (len_oct == 0) open_contents(cnt_left);
         end
         default: content_byte(b);
      endcase
   endfunction

   function automatic void clear_parse();
      pdu_left = 0;
      vb_left = 0;
      cls_tag = 0;
      cnt_left = 0;
      len_oct = 0;
      acc = 0;
      groups = 0;
      hdr_idx = 0;
      part = T_TAG;
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic sof, logic [15:0] mlen);
      bit ended;
      step_out.delete();
      if (sof) begin
         clear_parse();
         msg_left = {16'd0, mlen};
         ph = (mlen < {8'd0, min_len}) ? PS_DEAD : PS_SEQ;
      end
      if (ph == PS_IDLE) return;
      ended = (msg_left <= 1);
      if (msg_left != 0) msg_left--;
      if (ph != PS_DEAD && ph != PS_TAIL) tlv_byte(b);
      if (ended) begin
         put_field(KIND_NONE, 32'd0, 1'b0, (ph == PS_TAIL) ? STATUS_ACCEPT : STATUS_REJECT);
         ph = PS_IDLE;
         part = T_TAG;
         msg_left = 0;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Clock, and the monitor that predicts on each request and checks results
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      result_type got, want;
      if (!reset) begin
         if (csr.valid && csr.ready) min_len = csr.data;
         if (req.valid && req.ready) begin
            decode_byte(req.data_byte, req.start_of_message, req.message_length);
            // A row with a typed-in expectation stands in for the prediction.
            if (typed_count == 0) step_out.delete();
            else if (typed_count > 0) begin
               step_out.delete();
               step_out.push_back(typed_res);
            end
            foreach (step_out[i]) fields_due.push_back(step_out[i]);
         end
         if (rsp.valid && rsp.ready) begin
            got.kind = rsp.field_kind;
            got.value = rsp.field_value;
            got.last = rsp.field_last;
            got.status = rsp.message_status;
            n_fields++;
            if (got.status == STATUS_ACCEPT) n_accept++;
            if (got.status == STATUS_REJECT) n_reject++;
            if (fields_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result kind %0d value %h last %0d status %0d",
                        $time, got.kind, got.value, got.last, got.status);
            end else begin
               want = fields_due.pop_front();
               if (got.kind !== want.kind) begin
                  errors++;
                  $display("%0t: field_kind expected %0d actual %0d", $time, want.kind, got.kind);
               end
               if (got.value !== want.value) begin
                  errors++;
                  $display("%0t: field_value expected %h actual %h", $time, want.value,
                           got.value);
               end
               if (got.last !== want.last) begin
                  errors++;
                  $display("%0t: field_last expected %0d actual %0d", $time, want.last, got.last);
               end
               if (got.status !== want.status) begin
                  errors++;
                  $display("%0t: message_status expected %0d actual %0d", $time, want.status,
                           got.status);
               end
            end
         end
      end
   end

   // The result side stalls about a fifth of the time, except in a calm stretch.
   always @(posedge clock) begin
      rsp.ready <= calm || ($urandom_range(99) >= 22);
   end

   // ------------------------------------------------------------------------
   // Message builders
   // ------------------------------------------------------------------------
   function automatic octets_type rand_octets(int lo, int hi);
      octets_type q;
      int n;
      n = $urandom_range(hi, lo);
      repeat (n) q.push_back(8'($urandom_range(255)));
      return q;
   endfunction

   // Wraps a body in a tag and a length in short form, in padded long form,
   // as the bare indefinite-looking 0x80, or now and then with five octets.
   function automatic octets_type wrap(logic [7:0] tag, octets_type body);
      octets_type q;
      int n, r, k;
      n = body.size();
      r = $urandom_range(99);
      q.push_back(tag);
      if (n == 0 && r < 15) q.push_back(8'h80);
      else if (n < 128 && r < 70) q.push_back(8'(n));
      else if (r >= 97) begin
         q.push_back(8'h85);
         repeat (4) q.push_back(8'h00);
         q.push_back(8'(n));
      end else begin
         k = (n < 256) ? 1 : 2;
         k = $urandom_range(4, k);
         q.push_back(8'h80 | 8'(k));
         for (int i = k - 1; i >= 0; i--) q.push_back(8'(n >> (8 * i)));
      end
      return {q, body};
   endfunction

   function automatic octets_type rand_oid();
      octets_type q;
      int nsub, ng;
      if ($urandom_range(99) < 5) return q;
      nsub = $urandom_range(4, 1);
      repeat (nsub) begin
         ng = ($urandom_range(99) < 60) ? 1 : $urandom_range(6, 2);
         for (int g = 0; g < ng; g++)
            q.push_back({g < ng - 1, 7'($urandom_range(127))});
      end
      // Sometimes the last subidentifier never terminates.
      if ($urandom_range(99) < 10) q[q.size() - 1][7] = 1'b1;
      return q;
   endfunction

   function automatic octets_type rand_value();
      logic [7:0] tags[14] = '{8'h02, 8'h04, 8'h05, 8'h06, 8'h40, 8'h41, 8'h42, 8'h43,
                               8'h44, 8'h46, 8'h80, 8'h1f, 8'hc5, 8'h66};
      logic [7:0] t;
      t = tags[$urandom_range(13)];
      case (t)
         8'h02, 8'h41, 8'h42, 8'h43: return wrap(t, rand_octets(0, 5));
         8'h04, 8'h40, 8'h44:        return wrap(t, rand_octets(0, 4));
         8'h05: return wrap(t, ($urandom_range(99) < 85) ? rand_octets(0, 0) : rand_octets(1, 2));
         8'h06: return wrap(t, rand_oid());
         default: return wrap(t, rand_octets(0, 3));
      endcase
   endfunction

   function automatic octets_type build_message();
      octets_type body, pdu, binds;
      logic [7:0] ptag;
      ptag = ($urandom_range(99) < 92) ? 8'hA0 + 8'($urandom_range(4)) : 8'($urandom_range(255));
      if (ptag[4:0] == 5'd4)
         pdu = {wrap(8'h06, rand_oid()), wrap(8'h40, rand_octets(4, 4)),
                wrap(8'h02, rand_octets(0, 2)), wrap(8'h02, rand_octets(0, 5)),
                wrap(8'h43, rand_octets(1, 4))};
      else
         pdu = {wrap(8'h02, rand_octets(0, 5)), wrap(8'h02, rand_octets(0, 1)),
                wrap(8'h02, rand_octets(0, 1))};
      repeat ($urandom_range(2)) binds = {binds, wrap(8'h30, {wrap(8'h06, rand_oid()),
                                                               rand_value()})};
      pdu = {pdu, wrap(8'h30, binds)};
      body = {wrap(8'h02, rand_octets(0, 2)), wrap(8'h04, rand_octets(0, 4)), wrap(ptag, pdu)};
      body = wrap(8'h30, body);
      // Bytes after the sequence are part of the message but carry nothing.
      if ($urandom_range(99) < 10) body = {body, rand_octets(1, 3)};
      return body;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   // The typed-in expectation changes together with the request it belongs to.
   task automatic send_request(logic [7:0] d, logic sof, logic [15:0] len,
                               int t_n = -1, result_type t_r = '0);
      typed_count <= t_n;
      typed_res <= t_r;
      req.valid <= 1'b1;
      req.data_byte <= d;
      req.start_of_message <= sof;
      req.message_length <= len;
      do @(posedge clock); while (!req.ready);
      sent++;
      calm = (sent >= 150 && sent < 230);
      if (!calm && $urandom_range(99) < 28) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (fields_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_min_length(logic [7:0] v);
      csr.data <= v;
      csr.valid <= 1'b1;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
   endtask

   task automatic send_message();
      octets_type m;
      int n, cut;
      logic [15:0] mlen;
      m = build_message();
      if ($urandom_range(99) < 8) m[$urandom_range(m.size() - 1)] = 8'($urandom_range(255));
      n = m.size();
      mlen = ($urandom_range(99) < 85) ? 16'(n) : 16'(n + $urandom_range(6) - 3);
      cut = ($urandom_range(99) < 5) ? $urandom_range(n - 1, 1) : n;
      // A dropped message: a random length, a few bytes, then a new start.
      if ($urandom_range(99) < 6) begin
         send_request(8'h30, 1'b1, 16'($urandom_range(65535)));
         repeat ($urandom_range(3, 1)) send_request(8'($urandom_range(255)), 1'b0,
                                                    16'($urandom_range(65535)));
      end
      for (int i = 0; i < cut; i++)
         send_request(m[i], i == 0, (i == 0) ? mlen : 16'($urandom_range(65535)));
      n_msgs++;
   endtask

   stim_row_type rows[31] = '{
      '{8'hFF, 1'b1, 16'd0, 1, VERDICT_REJECT},   // empty message, all ones byte
      '{8'h30, 1'b1, 16'd1, 1, VERDICT_REJECT},   // one byte, below the minimum
      '{8'h55, 1'b0, 16'hFFFF, 0, NO_RESULT},     // stray byte while idle
      // A complete get request: version 0, community "p", one varbind with a null.
      '{8'h30, 1'b1, 16'd28, -1, NO_RESULT}, '{8'h1A, 1'b0, 16'd0, -1, NO_RESULT},
      '{8'h02, 1'b0, 16'd0, -1, NO_RESULT}, '{8'h01, 1'b0, 16'd0, -1, NO_RESULT},
      '{8'h00, 1'b0, 16'd0, -1, NO_RESULT}, '{8'h04, 1'b0, 16'd0, -1, NO_RESULT},
      '{8'h01, 1'b0, 16'd0, -1, NO_RESULT}, '{8'h70, 1'b0, 16'd0, -1, NO_RESULT},
      '{8'hA0, 1'b0, 16'd0, -1, NO_RESULT}, '{8'h12, 1'b0, 16'd0, -1, NO_RESULT},
      '{8'h02, 1'b0, 16'd0, -1, NO_RESULT}, '{8'h01, 1'b0, 16'd0, -1, NO_RESULT},
      '{8'h05, 1'b0, 16'd0, -1, NO_RESULT}, '{8'h02, 1'b0, 16'd0, -1, NO_RESULT},
      '{8'h01, 1'b0, 16'd0, -1, NO_RESULT}, '{8'h00, 1'b0, 16'd0, -1, NO_RESULT},
      '{8'h02, 1'b0, 16'd0, -1, NO_RESULT}, '{8'h01, 1'b0, 16'd0, -1, NO_RESULT},
      '{8'h00, 1'b0, 16'd0, -1, NO_RESULT}, '{8'h30, 1'b0, 16'd0, -1, NO_RESULT},
      '{8'h07, 1'b0, 16'd0, -1, NO_RESULT}, '{8'h30, 1'b0, 16'd0, -1, NO_RESULT},
      '{8'h05, 1'b0, 16'd0, -1, NO_RESULT}, '{8'h06, 1'b0, 16'd0, -1, NO_RESULT},
      '{8'h01, 1'b0, 16'd0, -1, NO_RESULT}, '{8'h2B, 1'b0, 16'd0, -1, NO_RESULT},
      '{8'h05, 1'b0, 16'd0, -1, NO_RESULT}, '{8'h00, 1'b0, 16'd0, -1, NO_RESULT}
   };

   initial begin
      logic [7:0] settings[4];
      settings = '{8'd0, 8'd255, 8'($urandom_range(60, 19)), MinLengthReset};
      min_len = MinLengthReset;
      ph = PS_IDLE;
      msg_left = 0;
      clear_parse();
      typed_count = -1;
      calm = 1'b0;
      sent = 0;
      errors = 0;
      n_fields = 0;
      n_accept = 0;
      n_reject = 0;
      n_msgs = 0;
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.data_byte <= 8'd0;
      req.start_of_message <= 1'b0;
      req.message_length <= 16'd0;
      csr.valid <= 1'b0;
      csr.data <= 8'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_request(rows[i].d, rows[i].sof, rows[i].len,
                                     rows[i].typed_n, rows[i].r);

      // Random messages at the reset minimum, then under each further setting.
      for (int p = -1; p < 4; p++) begin
         if (p >= 0) begin
            drain();
            write_min_length(settings[p]);
         end
         while (sent < 31 + 70 * (p + 2)) begin
            if ($urandom_range(99) < 10)
               send_request(8'($urandom_range(255)), 1'b0, 16'($urandom_range(65535)));
            send_message();
         end
      end
      drain();

      $display("covered %0d requests in %0d messages under five minimum length settings",
               sent, n_msgs);
      $display("checked %0d results, %0d accepted and %0d rejected verdicts",
               n_fields, n_accept, n_reject);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
